/* design/hrbd_pkg.sv */
// Shared types, constants and character tables of the HTTP response body deframer.
package hrbd_pkg;

    // Width of the length and chunk size counters
    localparam int COUNT_WIDTH = 32;

    typedef logic [7:0]             t_byte;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [4:0]             t_name_len;

    // Character codes
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_COLON = 8'h3A;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;
    localparam t_byte CH_LA    = 8'h61;
    localparam t_byte CH_LF_HEX = 8'h66;
    localparam t_byte CH_UA    = 8'h41;
    localparam t_byte CH_UF    = 8'h46;

    // Header names matched while the name part of a line streams in
    localparam t_name_len CL_LEN   = 5'd14;
    localparam t_name_len TE_LEN   = 5'd17;
    localparam t_name_len NAME_SAT = 5'd31;

    // Decoder phase
    typedef enum logic [3:0] {
        PH_HDR   = 4'd0,
        PH_LEN   = 4'd1,
        PH_CSIZE = 4'd2,
        PH_CDATA = 4'd3,
        PH_CCR   = 4'd4,
        PH_CLF   = 4'd5,
        PH_TCR   = 4'd6,
        PH_TLF   = 4'd7,
        PH_DONE  = 4'd8
    } t_phase;

    // Body framing; code zero on the framing output means still in header
    typedef enum logic [1:0] {
        MODE_NONE    = 2'd1,
        MODE_LENGTH  = 2'd2,
        MODE_CHUNKED = 2'd3
    } t_mode;

    localparam logic [1:0] FRAMING_HEADER = 2'd0;

    typedef struct packed {
        t_phase    phase;
        logic      colon_seen;
        logic      prev_was_cr;
        t_name_len name_length;
        logic      match_len;
        logic      match_enc;
        t_count    value_acc;
        logic      digits_started;
        t_mode     body_mode;
        t_count    length_value;
        t_count    remaining;
        logic      hex_stopped;
        logic      error_flag;
    } t_state;

    typedef struct packed {
        t_byte      body_byte;
        logic       body_valid;
        logic [1:0] framing;
        logic       message_done;
        logic       crlf_error;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:          PH_HDR,
        colon_seen:     1'b0,
        prev_was_cr:    1'b0,
        name_length:    '0,
        match_len:      1'b1,
        match_enc:      1'b1,
        value_acc:      '0,
        digits_started: 1'b0,
        body_mode:      MODE_NONE,
        length_value:   '0,
        remaining:      '0,
        hex_stopped:    1'b0,
        error_flag:     1'b0
    };

    // "Content-Length", one character per position
    function automatic t_byte cl_char(input t_name_len idx);
        t_byte c;
        unique case (idx)
            5'd0:    c = 8'h43;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h2D;
            5'd8:    c = 8'h4C;
            5'd9:    c = 8'h65;
            5'd10:   c = 8'h6E;
            5'd11:   c = 8'h67;
            5'd12:   c = 8'h74;
            5'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Transfer-Encoding", one character per position
    function automatic t_byte te_char(input t_name_len idx);
        t_byte c;
        unique case (idx)
            5'd0:    c = 8'h54;
            5'd1:    c = 8'h72;
            5'd2:    c = 8'h61;
            5'd3:    c = 8'h6E;
            5'd4:    c = 8'h73;
            5'd5:    c = 8'h66;
            5'd6:    c = 8'h65;
            5'd7:    c = 8'h72;
            5'd8:    c = 8'h2D;
            5'd9:    c = 8'h45;
            5'd10:   c = 8'h6E;
            5'd11:   c = 8'h63;
            5'd12:   c = 8'h6F;
            5'd13:   c = 8'h64;
            5'd14:   c = 8'h69;
            5'd15:   c = 8'h6E;
            5'd16:   c = 8'h67;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/hrbd_in_if.sv */
// Input word channel of the deframer: one raw response byte per word.
interface hrbd_in_if;
    import hrbd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

/* design/hrbd_out_if.sv */
// Result word channel of the deframer: body byte and framing status per input byte.
interface hrbd_out_if;
    import hrbd_pkg::*;

    logic       valid;
    logic       ready;
    t_byte      body_byte;
    logic       body_valid;
    logic [1:0] framing;
    logic       message_done;
    logic       crlf_error;

    modport source (
        output valid, output body_byte, output body_valid, output framing,
        output message_done, output crlf_error, input ready
    );
    modport sink (
        input valid, input body_byte, input body_valid, input framing,
        input message_done, input crlf_error, output ready
    );
endinterface

/* design/hrbd_step.sv */
// Per-byte state update of the deframer: header parse, length and chunk framing.
module hrbd_step (
    input  hrbd_pkg::t_state  i_state,
    input  hrbd_pkg::t_byte   i_byte,
    output hrbd_pkg::t_state  o_state,
    output hrbd_pkg::t_result o_result
);
    import hrbd_pkg::*;

    localparam int CW = COUNT_WIDTH;

    t_state n_st;
    logic   line_end;
    logic   is_digit;
    logic   hex_ok;
    logic [3:0] hex_val;

    // acc * 10 + d, saturating at all ones
    function automatic t_count sat_dec(input t_count acc, input logic [3:0] d);
        logic [CW+3:0] wide;
        wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {{CW{1'b0}}, d};
        return (wide[CW+3:CW] != 4'b0000) ? '1 : wide[CW-1:0];
    endfunction

    // acc * 16 + d, saturating at all ones
    function automatic t_count sat_hex(input t_count acc, input logic [3:0] d);
        return (acc[CW-1:CW-4] != 4'b0000) ? '1 : {acc[CW-5:0], d};
    endfunction

    // Append one character to the header name and track both name matches
    function automatic t_state add_name(input t_state s, input t_byte c);
        t_state r;
        r = s;
        if (s.name_length >= CL_LEN || cl_char(s.name_length) != c) begin
            r.match_len = 1'b0;
        end
        if (s.name_length >= TE_LEN || te_char(s.name_length) != c) begin
            r.match_enc = 1'b0;
        end
        if (s.name_length != NAME_SAT) begin
            r.name_length = s.name_length + 5'd1;
        end
        return r;
    endfunction

    function automatic t_state line_start(input t_state s);
        t_state r;
        r = s;
        r.colon_seen     = 1'b0;
        r.prev_was_cr    = 1'b0;
        r.name_length    = '0;
        r.match_len      = 1'b1;
        r.match_enc      = 1'b1;
        r.value_acc      = '0;
        r.digits_started = 1'b0;
        r.hex_stopped    = 1'b0;
        return r;
    endfunction

    // Byte classes
    assign line_end = (i_byte == CH_LF) && i_state.prev_was_cr;
    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = i_byte[3:0];
        priority if (is_digit) begin
            hex_val = i_byte[3:0];
        end else if ((i_byte >= CH_LA && i_byte <= CH_LF_HEX) ||
                     (i_byte >= CH_UA && i_byte <= CH_UF)) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_st = i_state;
        unique case (i_state.phase)
            PH_HDR: begin
                if (!i_state.colon_seen) begin
                    // a lone CR belongs to the name
                    if (i_state.prev_was_cr && !line_end) begin
                        n_st = add_name(n_st, CH_CR);
                    end
                    if (!line_end) begin
                        if (i_byte == CH_COLON) begin
                            n_st.colon_seen = 1'b1;
                        end else if (i_byte != CH_CR) begin
                            n_st = add_name(n_st, i_byte);
                        end
                    end
                end else if (!line_end && !i_state.hex_stopped) begin
                    // decimal value: skip leading spaces, stop at first non-digit
                    if (is_digit) begin
                        n_st.value_acc      = sat_dec(i_state.value_acc, i_byte[3:0]);
                        n_st.digits_started = 1'b1;
                    end else if (!(i_byte == CH_SPACE && !i_state.digits_started)) begin
                        n_st.hex_stopped = 1'b1;
                    end
                end
                n_st.prev_was_cr = (i_byte == CH_CR);
                if (line_end) begin
                    if (n_st.name_length == '0) begin
                        // blank line: header done, pick framing
                        priority if (n_st.body_mode == MODE_CHUNKED) begin
                            n_st.phase       = PH_CSIZE;
                            n_st.remaining   = '0;
                            n_st.hex_stopped = 1'b0;
                            n_st.prev_was_cr = 1'b0;
                        end else if (n_st.body_mode == MODE_LENGTH &&
                                     n_st.length_value != '0) begin
                            n_st.phase     = PH_LEN;
                            n_st.remaining = n_st.length_value;
                        end else begin
                            n_st.phase = PH_DONE;
                        end
                    end else begin
                        if (n_st.match_len && n_st.name_length == CL_LEN) begin
                            n_st.body_mode    = MODE_LENGTH;
                            n_st.length_value = n_st.value_acc;
                        end
                        if (n_st.match_enc && n_st.name_length == TE_LEN) begin
                            n_st.body_mode = MODE_CHUNKED;
                        end
                        n_st = line_start(n_st);
                    end
                end
            end
            PH_LEN: begin
                n_st.remaining = i_state.remaining - 1'b1;
                if (n_st.remaining == '0) begin
                    n_st.phase = PH_DONE;
                end
            end
            PH_CSIZE: begin
                if (line_end) begin
                    n_st.prev_was_cr = 1'b0;
                    n_st.phase = (i_state.remaining == '0) ? PH_TCR : PH_CDATA;
                end else begin
                    if (!i_state.hex_stopped) begin
                        if (hex_ok) begin
                            n_st.remaining = sat_hex(i_state.remaining, hex_val);
                        end else begin
                            n_st.hex_stopped = 1'b1;
                        end
                    end
                    n_st.prev_was_cr = (i_byte == CH_CR);
                end
            end
            PH_CDATA: begin
                n_st.remaining = i_state.remaining - 1'b1;
                if (n_st.remaining == '0) begin
                    n_st.phase = PH_CCR;
                end
            end
            PH_CCR: begin
                n_st.prev_was_cr = (i_byte == CH_CR);
                n_st.phase       = PH_CLF;
            end
            PH_TCR: begin
                n_st.prev_was_cr = (i_byte == CH_CR);
                n_st.phase       = PH_TLF;
            end
            PH_CLF, PH_TLF: begin
                // both bytes after chunk data are taken before the check
                priority if (!line_end) begin
                    n_st.error_flag = 1'b1;
                    n_st.phase      = PH_DONE;
                end else if (i_state.phase == PH_TLF) begin
                    n_st.phase = PH_DONE;
                end else begin
                    n_st.phase       = PH_CSIZE;
                    n_st.remaining   = '0;
                    n_st.hex_stopped = 1'b0;
                end
                n_st.prev_was_cr = 1'b0;
            end
            default: begin
                n_st.phase = PH_DONE;
            end
        endcase
    end

    // Result word
    always_comb begin
        o_result.body_valid   = (i_state.phase == PH_LEN) || (i_state.phase == PH_CDATA);
        o_result.body_byte    = o_result.body_valid ? i_byte : '0;
        o_result.framing      = (n_st.phase == PH_HDR) ? FRAMING_HEADER : n_st.body_mode;
        o_result.message_done = (n_st.phase == PH_DONE);
        o_result.crlf_error   = n_st.error_flag;
    end

    assign o_state = n_st;

endmodule

/* design/http_response_body_deframer.sv */
// HTTP/1.1 response body deframer top level: channels, stage registers, checks.
//
// Feed the raw bytes of one HTTP/1.1 response on i_in, one byte per word.
// For every byte accepted, exactly one result word leaves on o_out, in order:
// body_byte/body_valid mark entity body bytes, framing reports the chosen
// body framing (header, none, content length, chunked), message_done rises
// once the message has ended and crlf_error flags chunk data, or the last chunk,
// not followed by CR LF. Bytes after the end still give one word each, marked
// done and carrying no body.
// Each accepted byte passes one input register, then the per-byte state
// update into the result register.
// Throughput is one byte per cycle while o_out.ready keeps results moving;
// the header state, chunk counter and result register update once per byte.
// Reset (synchronous, active low) returns the parser to the start of the
// header and empties both stage registers; no clearing pass is needed.
// When the receiver stalls, the result register holds its word, the input
// register fills, and i_in.ready drops until o_out.ready returns.
module http_response_body_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrbd_in_if.sink           i_in,
    hrbd_out_if.source        o_out
);
    import hrbd_pkg::*;

    logic    r_in_valid;
    t_byte   r_in_byte;
    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    advance;

    // Stage control
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    hrbd_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.body_byte    = r_out.body_byte;
    assign o_out.body_valid   = r_out.body_valid;
    assign o_out.framing      = r_out.framing;
    assign o_out.message_done = r_out.message_done;
    assign o_out.crlf_error   = r_out.crlf_error;

    // Checks
    a_empty_out_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while result register empty");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_DONE |=> r_state.phase == PH_DONE)
        else $error("message end was left");

    a_body_needs_framing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.body_valid) |->
            (r_out.framing == MODE_LENGTH || r_out.framing == MODE_CHUNKED))
        else $error("body byte without body framing");

    a_error_ends_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.crlf_error) |-> r_out.message_done)
        else $error("chunk end error without message end");

endmodule
